FILE: design/line_end_index_and_locator_core_macros.svh
// Assertion macros shared by the line locator design.
`ifndef LINE_END_INDEX_AND_LOCATOR_CORE_MACROS_SVH
`define LINE_END_INDEX_AND_LOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LEIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define LEIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/leil_pkg.sv
package leil_pkg;

    localparam int MAX_LINES = 1024;
    localparam int POS_W     = 32;
    localparam int ADDR_W    = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int LINE_W    = 11;
    localparam int COL_W     = POS_W + 1;

    localparam logic [7:0] NL_BYTE = 8'd10;

    localparam logic FN_SCAN  = 1'b0;
    localparam logic FN_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOP,
        ST_CMP,
        ST_PREV
    } t_srch_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [POS_W-1:0]  data;
    } t_wr_req;

    typedef struct packed {
        logic busy;
    } t_srch_stat;

endpackage

FILE: design/leil_mem.sv
module leil_mem (
    input  logic                      i_clk,
    input  leil_pkg::t_wr_req         i_wr,
    input  leil_pkg::t_rd_req         i_rd,
    output logic [leil_pkg::POS_W-1:0] o_rd_data
);

    logic [leil_pkg::POS_W-1:0] r_mem [leil_pkg::MAX_LINES];
    logic [leil_pkg::POS_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/leil_search.sv
module leil_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [leil_pkg::POS_W-1:0]  i_pos,
    input  logic [leil_pkg::CNT_W-1:0]  i_count,
    input  logic [leil_pkg::POS_W-1:0]  i_rd_data,
    output leil_pkg::t_rd_req           o_rd,
    output leil_pkg::t_srch_stat        o_stat,
    output logic                        o_valid,
    output logic [leil_pkg::LINE_W-1:0] o_line_number,
    output logic [leil_pkg::COL_W-1:0]  o_column_number
);

    leil_pkg::t_srch_state r_state, n_state;
    logic [leil_pkg::CNT_W-1:0]  r_lo, n_lo;
    logic [leil_pkg::CNT_W-1:0]  r_hi, n_hi;
    logic [leil_pkg::ADDR_W-1:0] r_mid, n_mid;
    logic [leil_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                        r_valid, n_valid;
    logic [leil_pkg::LINE_W-1:0] r_line, n_line;
    logic [leil_pkg::COL_W-1:0]  r_col, n_col;

    logic [leil_pkg::CNT_W:0]    mid_sum;
    logic [leil_pkg::ADDR_W-1:0] mid;
    logic [leil_pkg::CNT_W-1:0]  lo_dec;
    logic [leil_pkg::POS_W-1:0]  operand;
    logic [leil_pkg::COL_W-1:0]  diff;

    // shared subtractor: borrow gives the compare, diff+1 gives the column
    // (operand is zero in ST_LOOP, used only when no end is at or below)
    assign operand = (r_state == leil_pkg::ST_LOOP) ? '0 : i_rd_data;
    assign diff    = {1'b0, r_pos} - {1'b0, operand};

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[leil_pkg::ADDR_W:1];
    assign lo_dec  = r_lo - leil_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= leil_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_pos  <= n_pos;
        r_line <= n_line;
        r_col  <= n_col;
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_pos   = r_pos;
        n_valid = 1'b0;
        n_line  = r_line;
        n_col   = r_col;
        o_rd.en   = 1'b0;
        o_rd.addr = mid;
        case (r_state)
            leil_pkg::ST_IDLE: begin
                if (i_go) begin
                    n_lo    = '0;
                    n_hi    = i_count;
                    n_pos   = i_pos;
                    n_state = leil_pkg::ST_LOOP;
                end
            end
            leil_pkg::ST_LOOP: begin
                if (r_lo < r_hi) begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = mid;
                    n_mid     = mid;
                    n_state   = leil_pkg::ST_CMP;
                end else if (r_lo == '0) begin
                    // no end at or below the position: column from zero
                    n_col   = diff + leil_pkg::COL_W'(1);
                    n_line  = leil_pkg::LINE_W'(r_lo + leil_pkg::CNT_W'(1));
                    n_valid = 1'b1;
                    n_state = leil_pkg::ST_IDLE;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = lo_dec[leil_pkg::ADDR_W-1:0];
                    n_state   = leil_pkg::ST_PREV;
                end
            end
            leil_pkg::ST_CMP: begin
                if (diff[leil_pkg::POS_W]) begin
                    n_hi = {{(leil_pkg::CNT_W - leil_pkg::ADDR_W){1'b0}}, r_mid};
                end else begin
                    n_lo = {{(leil_pkg::CNT_W - leil_pkg::ADDR_W){1'b0}}, r_mid}
                           + leil_pkg::CNT_W'(1);
                end
                n_state = leil_pkg::ST_LOOP;
            end
            leil_pkg::ST_PREV: begin
                n_col   = diff + leil_pkg::COL_W'(1);
                n_line  = leil_pkg::LINE_W'(r_lo + leil_pkg::CNT_W'(1));
                n_valid = 1'b1;
                n_state = leil_pkg::ST_IDLE;
            end
            default: begin
                n_state = leil_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stat.busy     = (r_state != leil_pkg::ST_IDLE);
    assign o_valid         = r_valid;
    assign o_line_number   = r_line;
    assign o_column_number = r_col;

endmodule

FILE: design/line_end_index_and_locator_core.sv
// Channel  | Signals                                       | Handshake
// ---------+-----------------------------------------------+----------------------------
// command  | i_func, i_data_byte, i_position               | i_start && !o_busy
// result   | o_line_number, o_column_number, o_table_full  | o_valid, one cycle, no stall (o_table_full: sticky flag)
//
// A scan beat is taken whenever busy is low and busy stays low, so scans stream back to back.
// A query alternates a read state and a compare state for each halving of the search range,
// then reads the end below lo in ST_PREV, or skips that read when no end lies at or below
// the position; the steps are set by the single registered read port of the end table and
// the one shared subtractor. o_valid strobes in the cycle busy falls.
// Synchronous active-low reset clears the count, last end and full flag; the table is
// not cleared, only entries below the count are read.
`include "line_end_index_and_locator_core_macros.svh"

module line_end_index_and_locator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_func,
    input  logic [7:0]                  i_data_byte,
    input  logic [leil_pkg::POS_W-1:0]  i_position,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic [leil_pkg::LINE_W-1:0] o_line_number,
    output logic [leil_pkg::COL_W-1:0]  o_column_number,
    output logic                        o_table_full
);

    logic [leil_pkg::CNT_W-1:0] r_end_count, n_end_count;
    logic [leil_pkg::POS_W-1:0] r_last_end, n_last_end;
    logic                       r_overflow, n_overflow;

    leil_pkg::t_rd_req    rd_req;
    leil_pkg::t_wr_req    wr_req;
    leil_pkg::t_srch_stat stat;
    logic [leil_pkg::POS_W-1:0] rd_data;

    logic                       accept;
    logic                       scan_nl;
    logic [leil_pkg::POS_W-1:0] new_end;
    logic                       stale;
    logic                       full;

    assign accept  = i_start && !stat.busy;
    // newline at the top position has no representable end
    assign scan_nl = accept && (i_func == leil_pkg::FN_SCAN)
                     && (i_data_byte == leil_pkg::NL_BYTE) && !(&i_position);
    assign new_end = i_position + leil_pkg::POS_W'(1);
    assign stale   = (r_end_count != '0) && (new_end <= r_last_end);
    assign full    = (r_end_count == leil_pkg::CNT_W'(leil_pkg::MAX_LINES));

    always_comb begin
        n_end_count = r_end_count;
        n_last_end  = r_last_end;
        n_overflow  = r_overflow;
        wr_req.en   = 1'b0;
        wr_req.addr = r_end_count[leil_pkg::ADDR_W-1:0];
        wr_req.data = new_end;
        if (scan_nl && !stale) begin
            if (full) begin
                n_overflow = 1'b1;
            end else begin
                wr_req.en   = 1'b1;
                n_end_count = r_end_count + leil_pkg::CNT_W'(1);
                n_last_end  = new_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_count <= '0;
            r_last_end  <= '0;
            r_overflow  <= 1'b0;
        end else begin
            r_end_count <= n_end_count;
            r_last_end  <= n_last_end;
            r_overflow  <= n_overflow;
        end
    end

    leil_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    leil_search u_search (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (accept && (i_func == leil_pkg::FN_QUERY)),
        .i_pos           (i_position),
        .i_count         (r_end_count),
        .i_rd_data       (rd_data),
        .o_rd            (rd_req),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number)
    );

    assign o_busy       = stat.busy;
    assign o_table_full = r_overflow;

    `LEIL_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `LEIL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_end_count <= leil_pkg::CNT_W'(leil_pkg::MAX_LINES))
    `LEIL_ASSERT_NXT(a_query_busy, i_clk, i_rst_n,
        i_start && !o_busy && (i_func == leil_pkg::FN_QUERY), o_busy)
    `LEIL_ASSERT_IMP(a_line_nonzero, i_clk, i_rst_n, o_valid, o_line_number != '0)

endmodule
